FILE: rtl/core/tmcs_pkg.sv
// ---------------------------------------------------------------------------
// tmcs_pkg
// Shared types, codes and constants for the trackpad motion converter.
// ---------------------------------------------------------------------------
`default_nettype none

package tmcs_pkg;

    // report kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CURSOR = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_SAMPLES    = 2'd1;
    localparam logic [1:0] CFG_GAP_MS     = 2'd2;

    localparam int CFG_W = 16;

    // reset values
    localparam logic [7:0]  BRIGHTNESS_RESET = 8'd60;
    localparam logic [7:0]  SAMPLES_RESET    = 8'd4;
    localparam logic [15:0] GAP_MS_RESET     = 16'd50;

    // cursor gain (40 + b) / 100, kept premultiplied by ceil(2^23 / 100)
    localparam int GAIN_BASE    = 40;
    localparam int DIV100_MUL   = 83887;
    localparam int DIV100_SHIFT = 23;
    localparam int GAIN_W       = 25;
    localparam logic [GAIN_W-1:0] GAIN_MUL_RESET =
        GAIN_W'((GAIN_BASE + int'(BRIGHTNESS_RESET)) * DIV100_MUL);

    // x / 3 as (x * 21846) >> 16, exact for x below 2^15
    localparam int DIV3_MUL   = 21846;
    localparam int DIV3_SHIFT = 16;

    typedef struct packed {
        logic              motion_active;
        logic              read_ok;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic              slow_key;
        logic              caps_lock;
        logic [31:0]       now_ms;
    } item_t;

    typedef struct packed {
        logic [1:0]         report_kind;
        logic signed [10:0] move_x;
        logic signed [10:0] move_y;
        logic signed [13:0] hwheel;
        logic signed [13:0] wheel;
        logic               touched;
    } result_t;

    typedef struct packed {
        logic [15:0] sum_x;
        logic [15:0] sum_y;
        logic [7:0]  sample_count;
        logic [31:0] last_time;
    } scroll_state_t;

    // magnitude of a sensor delta, halved (toward zero) when slow is set
    function automatic logic [7:0] halve_mag(input logic signed [7:0] d, input logic slow);
        logic [7:0] mag;
        mag = d[7] ? 8'(-d) : 8'(d);
        return slow ? (mag >> 1) : mag;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tmcs_cursor.sv
// ---------------------------------------------------------------------------
// tmcs_cursor
// Cursor move scaling: t = d*3/2 (d halved first when slow), then t*(40+b)/100, truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module tmcs_cursor
    import tmcs_pkg::*;
(
    input  wire item_t              item,
    input  wire logic [GAIN_W-1:0]  gain_mul,
    output logic signed [10:0]      move_x,
    output logic signed [10:0]      move_y
);

    // sign-magnitude path; truncation toward zero is symmetric
    function automatic logic signed [10:0] scale(input logic signed [7:0] d,
                                                 input logic slow,
                                                 input logic [GAIN_W-1:0] g);
        logic [7:0]  mag;
        logic [9:0]  t3;
        logic [7:0]  t;
        logic [32:0] prod;
        logic [9:0]  q;
        mag  = halve_mag(d, slow);
        t3   = 10'(mag) * 10'd3;
        t    = t3[8:1];
        prod = 33'(t) * 33'(g);
        q    = prod[32:DIV100_SHIFT];
        return d[7] ? -11'(q) : 11'(q);
    endfunction

    assign move_x = scale(item.delta_x, item.slow_key, gain_mul);
    assign move_y = scale(item.delta_y, item.slow_key, gain_mul);

endmodule

`default_nettype wire

FILE: rtl/core/tmcs_scroll.sv
// ---------------------------------------------------------------------------
// tmcs_scroll
// Scroll accumulation, run restart and tiered wheel mapping for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module tmcs_scroll
    import tmcs_pkg::*;
(
    input  wire item_t          item,
    input  wire scroll_state_t  state,
    input  wire logic [7:0]     samples_per_scroll,
    input  wire logic [15:0]    gap_ms,
    output scroll_state_t       state_next,
    output logic                report,
    output logic signed [13:0]  hwheel,
    output logic signed [13:0]  wheel
);

    localparam logic [2:0] TIER_24   = 3'd0;
    localparam logic [2:0] TIER_16   = 3'd1;
    localparam logic [2:0] TIER_12   = 3'd2;
    localparam logic [2:0] TIER_8    = 3'd3;
    localparam logic [2:0] TIER_SGN  = 3'd4;
    localparam logic [2:0] TIER_SGNX = 3'd5;

    logic [7:0]  mag_x, mag_y;
    logic [15:0] dh_x, dh_y;
    logic [31:0] elapsed;
    logic        restart;
    logic [15:0] sum_x_new, sum_y_new;
    logic [7:0]  count_new;
    logic [15:0] abs_x, abs_y;
    logic [2:0]  tier;
    logic [15:0] q_x, q_y;
    logic        wheel_zero;

    function automatic logic [15:0] quot(input logic [15:0] mag, input logic [2:0] t);
        logic [13:0] x3;
        logic [29:0] prod;
        logic [15:0] q;
        x3   = (t == TIER_24) ? 14'(mag >> 3) : 14'(mag >> 2);
        prod = 30'(x3) * 30'(DIV3_MUL);
        q    = 16'(prod[29:DIV3_SHIFT]);
        unique case (t)
            TIER_24, TIER_12: quot = q;
            TIER_16:          quot = mag >> 4;
            TIER_8:           quot = mag >> 3;
            default:          quot = 16'(mag != 16'd0);
        endcase
    endfunction

    assign mag_x = halve_mag(item.delta_x, item.slow_key);
    assign mag_y = halve_mag(item.delta_y, item.slow_key);
    assign dh_x  = item.delta_x[7] ? -16'(mag_x) : 16'(mag_x);
    assign dh_y  = item.delta_y[7] ? -16'(mag_y) : 16'(mag_y);

    // zero move or idle gap starts a new run
    assign elapsed = item.now_ms - state.last_time;
    assign restart = ((mag_x == 8'd0) && (mag_y == 8'd0)) || (elapsed > 32'(gap_ms));

    assign sum_x_new = (restart ? 16'd0 : state.sum_x) + dh_x;
    assign sum_y_new = (restart ? 16'd0 : state.sum_y) + dh_y;
    assign count_new = (restart ? 8'd0 : state.sample_count) + 8'd1;
    assign report    = count_new >= samples_per_scroll;

    always_comb
    begin
        state_next.last_time = item.now_ms;
        if (report)
        begin
            state_next.sum_x        = 16'd0;
            state_next.sum_y        = 16'd0;
            state_next.sample_count = 8'd0;
        end
        else
        begin
            state_next.sum_x        = sum_x_new;
            state_next.sum_y        = sum_y_new;
            state_next.sample_count = count_new;
        end
    end

    assign abs_x = sum_x_new[15] ? -sum_x_new : sum_x_new;
    assign abs_y = sum_y_new[15] ? -sum_y_new : sum_y_new;

    always_comb
    begin
        priority if (abs_y >= 16'd128) tier = TIER_24;
        else if (abs_y >= 16'd64)      tier = TIER_16;
        else if (abs_y >= 16'd32)      tier = TIER_12;
        else if (abs_y >= 16'd21)      tier = TIER_8;
        else if (abs_y >= 16'd3)       tier = TIER_SGN;
        else                           tier = TIER_SGNX;
    end

    assign q_x        = quot(abs_x, tier);
    assign q_y        = quot(abs_y, tier);
    assign wheel_zero = (tier == TIER_SGNX);

    // wheel is the negated vertical quotient
    assign hwheel = sum_x_new[15] ? -14'(q_x) : 14'(q_x);
    assign wheel  = wheel_zero ? 14'sd0 : (sum_y_new[15] ? 14'(q_y) : -14'(q_y));

endmodule

`default_nettype wire

FILE: rtl/core/trackpad_motion_to_cursor_scroll.sv
// ---------------------------------------------------------------------------
// trackpad_motion_to_cursor_scroll
// Poll-tick to cursor move / scroll report converter, one result per item.
// ---------------------------------------------------------------------------
// Path: an accepted item sits in the input register, and its result is then
//   registered onto m_axis, held back only while m_axis_tready is low.
// Throughput: one item per clock while m_axis_tready is high; the state loops
//   (scroll state, caps history, touch flag) update together with the result register.
// Reset: rst_n clears valid flags, scroll sums, count, caps history, last
//   timestamp and touch flag; config returns to brightness 60, 4 samples, 50 ms.
`default_nettype none

module trackpad_motion_to_cursor_scroll
    import tmcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] motion_active, [8:1] delta_x, [16:9] delta_y, [17] slow_key,
    // [49:18] now_ms, [55:50] zero
    input  wire logic [55:0] s_axis_tdata,
    // [0] read_ok, [1] caps_lock
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] move_x, [21:11] move_y, [35:22] hwheel, [49:36] wheel,
    // [50] touched, [55:51] zero
    output logic [55:0]      m_axis_tdata,
    // [1:0] report_kind
    output logic [1:0]       m_axis_tuser
);

    // -----------------------------------------------------------------
    // configuration registers; brightness is held as its premultiplied gain
    // -----------------------------------------------------------------
    logic [GAIN_W-1:0] gain_mul_reg, gain_mul_next;
    logic [7:0]        samples_reg;
    logic [15:0]       gap_ms_reg;

    assign gain_mul_next = GAIN_W'((9'(cfg_wdata[7:0]) + 9'(GAIN_BASE)) * 26'(DIV100_MUL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_mul_reg <= GAIN_MUL_RESET;
            samples_reg  <= SAMPLES_RESET;
            gap_ms_reg   <= GAP_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: gain_mul_reg <= gain_mul_next;
                CFG_SAMPLES:    samples_reg  <= cfg_wdata[7:0];
                CFG_GAP_MS:     gap_ms_reg   <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // -----------------------------------------------------------------
    // handshake: input register feeds result register; while m_axis_tready is high, one item per clock
    // -----------------------------------------------------------------
    logic    in_valid_reg, in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    s_accept, m_accept, advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = out_valid_reg && m_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_accept ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.motion_active <= s_axis_tdata[0];
            item_reg.read_ok       <= s_axis_tuser[0];
            item_reg.delta_x       <= s_axis_tdata[8:1];
            item_reg.delta_y       <= s_axis_tdata[16:9];
            item_reg.slow_key      <= s_axis_tdata[17];
            item_reg.caps_lock     <= s_axis_tuser[1];
            item_reg.now_ms        <= s_axis_tdata[49:18];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // -----------------------------------------------------------------
    // tracking state
    // -----------------------------------------------------------------
    scroll_state_t scroll_reg, scroll_next;
    logic          prev_caps_reg;
    logic          touch_reg, touch_next;

    scroll_state_t scroll_calc;
    logic          scroll_report;
    logic signed [10:0] cur_x, cur_y;
    logic signed [13:0] hw_calc, wh_calc;
    logic          caps_fall;
    logic          scroll_branch;

    tmcs_cursor u_cursor (
        .item     (item_reg),
        .gain_mul (gain_mul_reg),
        .move_x   (cur_x),
        .move_y   (cur_y)
    );

    tmcs_scroll u_scroll (
        .item               (item_reg),
        .state              (scroll_reg),
        .samples_per_scroll (samples_reg),
        .gap_ms             (gap_ms_reg),
        .state_next         (scroll_calc),
        .report             (scroll_report),
        .hwheel             (hw_calc),
        .wheel              (wh_calc)
    );

    assign caps_fall     = prev_caps_reg && !item_reg.caps_lock;
    assign scroll_branch = item_reg.motion_active && item_reg.read_ok && item_reg.caps_lock;

    always_comb
    begin
        scroll_next = scroll_reg;
        touch_next  = touch_reg;
        result_next = '0;

        // leaving scroll mode drops any partial run
        if (caps_fall)
        begin
            scroll_next.sum_x        = 16'd0;
            scroll_next.sum_y        = 16'd0;
            scroll_next.sample_count = 8'd0;
        end

        if (!item_reg.motion_active)
        begin
            touch_next = 1'b0;
        end
        else if (item_reg.read_ok)
        begin
            if (!item_reg.caps_lock)
            begin
                touch_next              = 1'b1;
                result_next.report_kind = KIND_CURSOR;
                result_next.move_x      = cur_x;
                result_next.move_y      = cur_y;
            end
            else
            begin
                scroll_next = scroll_calc;
                if (scroll_report)
                begin
                    result_next.report_kind = KIND_SCROLL;
                    result_next.hwheel      = hw_calc;
                    result_next.wheel       = wh_calc;
                end
            end
        end

        result_next.touched = touch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_reg    <= '0;
            prev_caps_reg <= 1'b0;
            touch_reg     <= 1'b0;
        end
        else if (advance)
        begin
            scroll_reg    <= scroll_next;
            prev_caps_reg <= item_reg.caps_lock;
            touch_reg     <= touch_next;
        end
    end

    // -----------------------------------------------------------------
    // output packing
    // -----------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.report_kind;
    assign m_axis_tdata  = {5'd0, result_reg.touched, result_reg.wheel, result_reg.hwheel,
                            result_reg.move_y, result_reg.move_x};

    // -----------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------
    a_cursor_touched: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.report_kind == KIND_CURSOR) |-> result_reg.touched)
        else $error("cursor move reported without touch flag");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && scroll_branch && scroll_report) |=>
            (scroll_reg.sample_count == 8'd0 && scroll_reg.sum_x == 16'd0))
        else $error("scroll report did not clear accumulators");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled while pipeline had room");

    a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.report_kind != KIND_SCROLL) |->
            (result_reg.hwheel == 14'sd0 && result_reg.wheel == 14'sd0))
        else $error("wheel values outside a scroll report");

endmodule

`default_nettype wire
